FILE: src/rspc_pkg.sv
// ----------------------------------------------------------------------------
// Range sum pair counter package
// Shared constants, register indexes and payload types of the block.
// ----------------------------------------------------------------------------
package rspc_pkg;

  // Width of one input element and of each range bound.
  localparam int unsigned DATA_W      = 32;
  // Width of the reported subarray count.
  localparam int unsigned COUNT_W     = 16;
  // Default longest sequence that is counted in full.
  localparam int unsigned MAX_LEN_DEF = 256;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W   = 1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 1'b1;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] pair_count;
    logic               too_long;
  } out_item_t;

  // Control flags of a token as it travels along the row of cells.
  typedef struct packed {
    logic valid;  // token carries an element
    logic last;   // element closes the sequence
    logic ign;    // element beyond the length limit, no compare, no store
    logic ovf;    // sequence has been truncated so far
  } tok_ctrl_t;

endpackage : rspc_pkg

FILE: src/range_sum_pair_counter_top.sv
// ----------------------------------------------------------------------------
// Range sum pair counter
// Counts the contiguous subarrays of a sequence whose sum lies in a closed
// range, using a row of cells that each hold one earlier prefix sum.
// ----------------------------------------------------------------------------
// Usage
//   Elements arrive on the input channel, one signed 32-bit value per
//   transfer, with last marking the final element of a sequence. One result
//   transfer leaves on the output channel per sequence, carrying the number
//   of subarrays whose sum lies within [range_low, range_high] and a flag
//   telling whether elements beyond MAX_LEN were dropped.
//   The bounds are written through the configuration channel (index 0 for
//   range_low, index 1 for range_high); the user must write them only while
//   no sequence is in flight, as the block does not enforce this. The
//   channel always accepts. Each accepted element becomes a token that
//   walks the row of MAX_LEN + 1 cells at one cell per cycle unless the
//   row is halted; the length of the cell row sets the latency. The row is
//   fully pipelined: one element is accepted every cycle unless the row
//   is halted, and a new sequence may follow directly. Reset empties every
//   cell and clears the bounds to zero; no clearing pass is needed. If the
//   receiver stalls while a result is held, the whole row freezes only
//   when a further result reaches the end of it, and input ready drops for
//   exactly that time.
// ----------------------------------------------------------------------------
module range_sum_pair_counter_top #(
  parameter int unsigned MAX_LEN = rspc_pkg::MAX_LEN_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  rspc_pkg::in_item_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output rspc_pkg::out_item_t                out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [rspc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rspc_pkg::DATA_W-1:0]        cfg_data_i
);
  import rspc_pkg::*;

  // Prefix sums need room for MAX_LEN full-scale elements; differences of
  // two prefixes need one bit more.
  localparam int unsigned PW    = DATA_W + $clog2(MAX_LEN);
  localparam int unsigned DW    = PW + 1;
  localparam int unsigned IW    = $clog2(MAX_LEN + 1);
  localparam int unsigned NW    = $clog2(MAX_LEN + 2);
  localparam int unsigned ACC_W = COUNT_W + 1;
  localparam int unsigned NCELL = MAX_LEN + 1;

  // Configuration registers.
  logic signed [DATA_W-1:0] range_low_q;
  logic signed [DATA_W-1:0] range_high_q;
  logic signed [DW-1:0]     range_low_ext;
  logic signed [DW-1:0]     range_high_ext;

  // Sequence state at the entry: running prefix, next free cell, truncation.
  logic [PW-1:0] run_q, run_d;
  logic [NW-1:0] fill_q, fill_d;
  logic          ovf_q, ovf_d;

  // Token register feeding the root cell.
  tok_ctrl_t     ent_ctrl_q, ent_ctrl_d;
  logic [PW-1:0] ent_prefix_q, ent_prefix_d;
  logic [IW-1:0] ent_idx_q, ent_idx_d;

  // Chain links between cells; link k feeds cell k.
  tok_ctrl_t     link_ctrl   [NCELL+1];
  logic [PW-1:0] link_prefix [NCELL+1];
  logic [IW-1:0] link_idx    [NCELL+1];
  logic [IW-1:0] link_count  [NCELL+1];

  // Result accumulation at the end of the row.
  logic [COUNT_W-1:0] sum_q, sum_d;
  logic [ACC_W-1:0]   acc;
  logic [COUNT_W-1:0] acc_sat;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_data_q, out_data_d;

  logic               en;
  logic               stall;
  logic               in_fire;
  logic               tail_valid;
  logic               tail_last;
  logic               room;
  logic [PW-1:0]      next_prefix;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q  <= '0;
      range_high_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_RANGE_LOW:  range_low_q  <= cfg_data_i;
        REG_RANGE_HIGH: range_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign range_low_ext  = {{(DW-DATA_W){range_low_q[DATA_W-1]}}, range_low_q};
  assign range_high_ext = {{(DW-DATA_W){range_high_q[DATA_W-1]}}, range_high_q};

  // ---------------------------------------------------------------------------
  // Flow control: the row only halts when a closing token reaches the end
  // while the previous result is still waiting for the receiver.
  // ---------------------------------------------------------------------------
  assign tail_valid = link_ctrl[NCELL].valid;
  assign tail_last  = link_ctrl[NCELL].last;
  assign stall      = tail_valid && tail_last && out_valid_q && !out_ready_i;
  assign en         = !stall;
  assign in_ready_o = en;
  assign in_fire    = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // Entry: running prefix and insertion slot of each element
  // ---------------------------------------------------------------------------
  assign room        = (fill_q <= NW'(MAX_LEN));
  assign next_prefix = run_q + {{(PW-DATA_W){in_data_i.value[DATA_W-1]}}, in_data_i.value};

  always_comb begin
    run_d        = run_q;
    fill_d       = fill_q;
    ovf_d        = ovf_q;
    ent_ctrl_d   = '0;
    ent_prefix_d = next_prefix;
    ent_idx_d    = fill_q[IW-1:0];

    if (in_fire) begin
      ent_ctrl_d.valid = 1'b1;
      ent_ctrl_d.last  = in_data_i.last;
      ent_ctrl_d.ign   = !room;
      ent_ctrl_d.ovf   = ovf_q || !room;
      if (room) begin
        run_d  = next_prefix;
        fill_d = fill_q + NW'(1);
      end else begin
        ovf_d = 1'b1;
      end
      // A closing element starts the next sequence from the empty prefix.
      if (in_data_i.last) begin
        run_d  = '0;
        fill_d = NW'(1);
        ovf_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q      <= '0;
      fill_q     <= NW'(1);
      ovf_q      <= 1'b0;
      ent_ctrl_q <= '0;
    end else if (en) begin
      run_q      <= run_d;
      fill_q     <= fill_d;
      ovf_q      <= ovf_d;
      ent_ctrl_q <= ent_ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ent_prefix_q <= ent_prefix_d;
      ent_idx_q    <= ent_idx_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Row of cells: cell 0 is the empty prefix, cell k holds the k-th prefix.
  // ---------------------------------------------------------------------------
  assign link_ctrl[0]   = ent_ctrl_q;
  assign link_prefix[0] = ent_prefix_q;
  assign link_idx[0]    = ent_idx_q;
  assign link_count[0]  = '0;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    rspc_cell #(
      .MAX_LEN  (MAX_LEN),
      .CELL_IDX (k)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .en_i         (en),
      .range_low_i  (range_low_ext),
      .range_high_i (range_high_ext),
      .tok_ctrl_i   (link_ctrl[k]),
      .tok_prefix_i (link_prefix[k]),
      .tok_idx_i    (link_idx[k]),
      .tok_count_i  (link_count[k]),
      .tok_ctrl_o   (link_ctrl[k+1]),
      .tok_prefix_o (link_prefix[k+1]),
      .tok_idx_o    (link_idx[k+1]),
      .tok_count_o  (link_count[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Tail: each token adds its matches; the count saturates at full scale.
  // ---------------------------------------------------------------------------
  assign acc     = ACC_W'(sum_q) + ACC_W'(link_count[NCELL]);
  assign acc_sat = acc[COUNT_W] ? {COUNT_W{1'b1}} : acc[COUNT_W-1:0];

  always_comb begin
    sum_d       = sum_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (tail_valid && en) begin
      if (tail_last) begin
        sum_d                 = '0;
        out_valid_d           = 1'b1;
        out_data_d.pair_count = acc_sat;
        out_data_d.too_long   = link_ctrl[NCELL].ovf;
      end else begin
        sum_d = acc_sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // The slot counter never leaves the range of the row.
  a_fill_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q >= NW'(1)) && (fill_q <= NW'(MAX_LEN + 1)))
    else $error("insertion slot out of range");

  // A closing element restarts the sequence state at the entry.
  a_seq_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.last) |=> (fill_q == NW'(1)) && (run_q == '0) && !ovf_q)
    else $error("sequence state not restarted after closing element");

  // A closing token leaving the row always produces a held result.
  a_result_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail_valid && tail_last && en) |=> out_valid_q)
    else $error("closing token did not produce a result");

  // The row only halts while a result is being held.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |-> out_valid_q && !out_ready_i)
    else $error("row halted without a pending result");

endmodule : range_sum_pair_counter_top

FILE: src/rspc_cell.sv
// ----------------------------------------------------------------------------
// Range sum pair counter cell
// Holds one stored prefix sum, tests the passing token against it and hands
// the token with its updated match count to the next cell.
// ----------------------------------------------------------------------------
module rspc_cell #(
  parameter int unsigned MAX_LEN  = rspc_pkg::MAX_LEN_DEF,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        en_i,
  input  logic signed [rspc_pkg::DATA_W+$clog2(MAX_LEN):0] range_low_i,
  input  logic signed [rspc_pkg::DATA_W+$clog2(MAX_LEN):0] range_high_i,
  input  rspc_pkg::tok_ctrl_t                         tok_ctrl_i,
  input  logic [rspc_pkg::DATA_W+$clog2(MAX_LEN)-1:0] tok_prefix_i,
  input  logic [$clog2(MAX_LEN+1)-1:0]                tok_idx_i,
  input  logic [$clog2(MAX_LEN+1)-1:0]                tok_count_i,
  output rspc_pkg::tok_ctrl_t                         tok_ctrl_o,
  output logic [rspc_pkg::DATA_W+$clog2(MAX_LEN)-1:0] tok_prefix_o,
  output logic [$clog2(MAX_LEN+1)-1:0]                tok_idx_o,
  output logic [$clog2(MAX_LEN+1)-1:0]                tok_count_o
);
  import rspc_pkg::*;

  localparam int unsigned PW = DATA_W + $clog2(MAX_LEN);
  localparam int unsigned DW = PW + 1;
  localparam int unsigned IW = $clog2(MAX_LEN + 1);

  logic [PW-1:0]        store_prefix;
  logic                 store_valid;
  logic signed [DW-1:0] diff;
  logic                 hit;
  logic                 active;

  tok_ctrl_t            ctrl_q;
  logic [PW-1:0]        prefix_q;
  logic [IW-1:0]        idx_q;
  logic [IW-1:0]        count_q;

  assign active = tok_ctrl_i.valid && !tok_ctrl_i.ign;

  // The root cell stands for the empty prefix, which is always present.
  if (CELL_IDX == 0) begin : g_root
    assign store_prefix = '0;
    assign store_valid  = 1'b1;
  end else begin : g_entry
    logic [PW-1:0] entry_q;
    logic          entry_valid_q;

    always_ff @(posedge clk_i) begin
      if (en_i && active && (tok_idx_i == IW'(CELL_IDX))) begin
        entry_q <= tok_prefix_i;
      end
    end

    // A closing token empties the cell behind it for the next sequence.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        entry_valid_q <= 1'b0;
      end else if (en_i && tok_ctrl_i.valid) begin
        if (tok_ctrl_i.last) begin
          entry_valid_q <= 1'b0;
        end else if (active && (tok_idx_i == IW'(CELL_IDX))) begin
          entry_valid_q <= 1'b1;
        end
      end
    end

    assign store_prefix = entry_q;
    assign store_valid  = entry_valid_q;
  end

  assign diff = $signed({tok_prefix_i[PW-1], tok_prefix_i})
              - $signed({store_prefix[PW-1], store_prefix});
  assign hit  = active && store_valid && (diff >= range_low_i) && (diff <= range_high_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= tok_ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prefix_q <= tok_prefix_i;
      idx_q    <= tok_idx_i;
      count_q  <= tok_count_i + IW'(hit);
    end
  end

  assign tok_ctrl_o   = ctrl_q;
  assign tok_prefix_o = prefix_q;
  assign tok_idx_o    = idx_q;
  assign tok_count_o  = count_q;

endmodule : rspc_cell
